// ===== hw/rtl/pcsp_pkg.sv =====
// Shared constants, result type, signature bytes and CRC-32 byte update for the PNG chunk stream parser.
`timescale 1ns / 1ps
`default_nettype none

package pcsp_pkg;

    localparam logic [2:0] KIND_OTHER   = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_PALETTE = 3'd2;
    localparam logic [2:0] KIND_IMAGE   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    localparam logic [2:0] ST_BUSY       = 3'd0;
    localparam logic [2:0] ST_BAD_SIG    = 3'd1;
    localparam logic [2:0] ST_BAD_HDRLEN = 3'd2;
    localparam logic [2:0] ST_CRC_ERR    = 3'd3;
    localparam logic [2:0] ST_NO_IMAGE   = 3'd4;
    localparam logic [2:0] ST_DONE       = 3'd5;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] HDR_LEN  = 32'd13;

    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [2:0]  chunk_kind;
        logic        chunk_done;
        logic [2:0]  status;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  sample_depth;
        logic [7:0]  color_kind;
        logic [7:0]  interlace_mode;
    } result_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h89;
            3'd1: v = 8'h50;
            3'd2: v = 8'h4e;
            3'd3: v = 8'h47;
            3'd4: v = 8'h0d;
            3'd5: v = 8'h0a;
            3'd6: v = 8'h1a;
            3'd7: v = 8'h0a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_feed(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcsp_core.sv =====
// Parser state, chunk framing and CRC check; produces the result for the byte being processed.
`timescale 1ns / 1ps
`default_nettype none

module pcsp_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [7:0]        data_byte,
    output pcsp_pkg::result_t      result
);
    import pcsp_pkg::*;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_HLEN,
        PH_HBODY,
        PH_HCRC,
        PH_CLEN,
        PH_CTYPE,
        PH_CDATA,
        PH_CCRC
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [31:0] chunk_type_reg, chunk_type_next;
    logic [31:0] crc_accum_reg, crc_accum_next;
    logic [31:0] crc_rx_reg, crc_rx_next;
    logic        seen_image_reg, seen_image_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [23:0] header_reg, header_next;

    logic [31:0] cnt_inc;
    logic [31:0] crc_fed;
    logic [31:0] rx_shift;
    logic [31:0] len_shift;
    logic [31:0] type_shift;
    logic [2:0]  kind;
    logic        pv;
    logic [7:0]  pb;
    logic        done;

    function automatic logic [2:0] kind_of(input logic [31:0] t);
        logic [2:0] k;
        if (t == TYPE_IDAT) begin
            k = KIND_IMAGE;
        end else if (t == TYPE_PLTE) begin
            k = KIND_PALETTE;
        end else if (t == TYPE_IEND) begin
            k = KIND_END;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

    assign cnt_inc    = byte_count_reg + 32'd1;
    assign crc_fed    = crc_feed(crc_accum_reg, data_byte);
    assign rx_shift   = {crc_rx_reg[23:0], data_byte};
    assign len_shift  = {chunk_length_reg[23:0], data_byte};
    assign type_shift = {chunk_type_reg[23:0], data_byte};

    always_comb begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        chunk_length_next = chunk_length_reg;
        chunk_type_next   = chunk_type_reg;
        crc_accum_next    = crc_accum_reg;
        crc_rx_next       = crc_rx_reg;
        seen_image_next   = seen_image_reg;
        status_next       = status_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        header_next       = header_reg;
        kind              = KIND_OTHER;
        pv                = 1'b0;
        pb                = 8'd0;
        done              = 1'b0;

        if (status_reg == ST_BUSY) begin
            case (phase_reg)
                PH_SIG: begin
                    if (data_byte != sig_byte(byte_count_reg[2:0])) begin
                        status_next = ST_BAD_SIG;
                    end else if (cnt_inc >= 32'd8) begin
                        phase_next        = PH_HLEN;
                        byte_count_next   = 32'd0;
                        chunk_length_next = 32'd0;
                    end else begin
                        byte_count_next = cnt_inc;
                    end
                end
                PH_HLEN: begin
                    kind              = KIND_HEADER;
                    chunk_length_next = len_shift;
                    byte_count_next   = cnt_inc;
                    if (cnt_inc >= 32'd4) begin
                        if (len_shift != HDR_LEN) begin
                            status_next = ST_BAD_HDRLEN;
                        end else begin
                            phase_next      = PH_HBODY;
                            byte_count_next = 32'd0;
                            crc_accum_next  = CRC_INIT;
                        end
                    end
                end
                PH_HBODY: begin
                    kind           = KIND_HEADER;
                    crc_accum_next = crc_fed;
                    if (byte_count_reg < 32'd4) begin
                        chunk_type_next = type_shift;
                    end else if (byte_count_reg < 32'd8) begin
                        width_next = {width_reg[23:0], data_byte};
                    end else if (byte_count_reg < 32'd12) begin
                        height_next = {height_reg[23:0], data_byte};
                    end else if (byte_count_reg == 32'd12) begin
                        header_next[23:16] = data_byte;
                    end else if (byte_count_reg == 32'd13) begin
                        header_next[15:8] = data_byte;
                    end else if (byte_count_reg == 32'd16) begin
                        header_next[7:0] = data_byte;
                    end
                    byte_count_next = cnt_inc;
                    if (cnt_inc >= 32'd17) begin
                        phase_next      = PH_HCRC;
                        byte_count_next = 32'd0;
                        crc_rx_next     = 32'd0;
                    end
                end
                PH_HCRC: begin
                    kind            = KIND_HEADER;
                    crc_rx_next     = rx_shift;
                    byte_count_next = cnt_inc;
                    if (cnt_inc >= 32'd4) begin
                        done = 1'b1;
                        if (~crc_accum_reg != rx_shift) begin
                            status_next = ST_CRC_ERR;
                        end else begin
                            phase_next        = PH_CLEN;
                            byte_count_next   = 32'd0;
                            chunk_length_next = 32'd0;
                        end
                    end
                end
                PH_CLEN: begin
                    chunk_length_next = len_shift;
                    byte_count_next   = cnt_inc;
                    if (cnt_inc >= 32'd4) begin
                        phase_next      = PH_CTYPE;
                        byte_count_next = 32'd0;
                        crc_accum_next  = CRC_INIT;
                    end
                end
                PH_CTYPE: begin
                    crc_accum_next  = crc_fed;
                    chunk_type_next = type_shift;
                    byte_count_next = cnt_inc;
                    if (cnt_inc >= 32'd4) begin
                        kind            = kind_of(type_shift);
                        byte_count_next = 32'd0;
                        crc_rx_next     = 32'd0;
                        if (kind == KIND_END) begin
                            status_next = seen_image_reg ? ST_DONE : ST_NO_IMAGE;
                        end else begin
                            if (kind == KIND_IMAGE) begin
                                seen_image_next = 1'b1;
                            end
                            phase_next = (chunk_length_reg != 32'd0) ? PH_CDATA : PH_CCRC;
                        end
                    end
                end
                PH_CDATA: begin
                    kind           = kind_of(chunk_type_reg);
                    crc_accum_next = crc_fed;
                    if (kind == KIND_PALETTE || kind == KIND_IMAGE) begin
                        pv = 1'b1;
                        pb = data_byte;
                    end
                    byte_count_next = cnt_inc;
                    if (cnt_inc >= chunk_length_reg) begin
                        phase_next      = PH_CCRC;
                        byte_count_next = 32'd0;
                        crc_rx_next     = 32'd0;
                    end
                end
                PH_CCRC: begin
                    kind            = kind_of(chunk_type_reg);
                    crc_rx_next     = rx_shift;
                    byte_count_next = cnt_inc;
                    if (cnt_inc >= 32'd4) begin
                        done = 1'b1;
                        if ((kind == KIND_PALETTE || kind == KIND_IMAGE)
                                && (~crc_accum_reg != rx_shift)) begin
                            status_next = ST_CRC_ERR;
                        end else begin
                            phase_next        = PH_CLEN;
                            byte_count_next   = 32'd0;
                            chunk_length_next = 32'd0;
                        end
                    end
                end
                default: begin
                    phase_next = PH_SIG;
                end
            endcase
        end
    end

    always_comb begin
        result.payload_byte   = pb;
        result.payload_valid  = pv;
        result.chunk_kind     = kind;
        result.chunk_done     = done;
        result.status         = status_next;
        result.image_width    = width_next;
        result.image_height   = height_next;
        result.sample_depth   = header_next[23:16];
        result.color_kind     = header_next[15:8];
        result.interlace_mode = header_next[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SIG;
            byte_count_reg   <= 32'd0;
            chunk_length_reg <= 32'd0;
            chunk_type_reg   <= 32'd0;
            crc_accum_reg    <= CRC_INIT;
            crc_rx_reg       <= 32'd0;
            seen_image_reg   <= 1'b0;
            status_reg       <= ST_BUSY;
            width_reg        <= 32'd0;
            height_reg       <= 32'd0;
            header_reg       <= 24'd0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            chunk_length_reg <= chunk_length_next;
            chunk_type_reg   <= chunk_type_next;
            crc_accum_reg    <= crc_accum_next;
            crc_rx_reg       <= crc_rx_next;
            seen_image_reg   <= seen_image_next;
            status_reg       <= status_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            header_reg       <= header_next;
        end
    end

    a_status_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg != ST_BUSY) |=> (status_reg == $past(status_reg)))
        else $error("status left a final code");

    a_done_in_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.chunk_done) |-> (phase_reg == PH_HCRC || phase_reg == PH_CCRC))
        else $error("chunk done outside a CRC field");

    a_busy_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && status_reg == ST_BUSY && phase_reg == PH_CDATA) |=>
            (phase_reg == PH_CDATA || phase_reg == PH_CCRC))
        else $error("data field left to an unexpected phase");

endmodule

`default_nettype wire

// ===== hw/rtl/png_chunk_stream_parser.sv =====
// Top level of the PNG chunk stream parser: input register, parser core and result register.
`timescale 1ns / 1ps
`default_nettype none
// Each byte goes through the input register and then the result register to the m_ side.
// One byte per cycle if m_ready holds; the core's CRC-32 byte update is the longest path.
// One result transfer per input transfer, in order; both sides may stall freely.
// Reset (aresetn low, synchronous): parser returns to the signature check, status busy,
// captured header fields zero, both pipeline registers empty.

module png_chunk_stream_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_payload_byte,
    output logic             m_payload_valid,
    output logic [2:0]       m_chunk_kind,
    output logic             m_chunk_done,
    output logic [2:0]       m_status,
    output logic [31:0]      m_image_width,
    output logic [31:0]      m_image_height,
    output logic [7:0]       m_sample_depth,
    output logic [7:0]       m_color_kind,
    output logic [7:0]       m_interlace_mode
);
    import pcsp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_result;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    pcsp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .result    (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_payload_valid  = out_reg.payload_valid;
    assign m_chunk_kind     = out_reg.chunk_kind;
    assign m_chunk_done     = out_reg.chunk_done;
    assign m_status         = out_reg.status;
    assign m_image_width    = out_reg.image_width;
    assign m_image_height   = out_reg.image_height;
    assign m_sample_depth   = out_reg.sample_depth;
    assign m_color_kind     = out_reg.color_kind;
    assign m_interlace_mode = out_reg.interlace_mode;

    a_payload_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.payload_valid) |->
            (out_reg.chunk_kind == KIND_PALETTE || out_reg.chunk_kind == KIND_IMAGE))
        else $error("payload transfer outside a palette or image chunk");

    a_payload_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.payload_valid) |->
            (out_reg.status == ST_BUSY && !out_reg.chunk_done))
        else $error("payload transfer with final status or on a CRC byte");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== verif/tb_png_chunk_stream_parser.sv =====
// Self-checking testbench for the PNG chunk stream parser: one byte stream per run.
`timescale 1ns / 1ps

module tb_png_chunk_stream_parser;
    import pcsp_pkg::*;

    localparam int          ITEM_TARGET    = 600;
    localparam int          HDR_ROWS       = 29;
    localparam int          HDR_TYPE_ROW   = 12;
    localparam int          SIG_BYTES      = 8;
    localparam int          MAX_PRINTS     = 40;
    localparam logic [31:0] TYPE_IHDR_WORD = 32'h4948_4452;
    localparam logic [31:0] TYPE_TEXT_WORD = 32'h7445_5874;

    typedef enum logic [2:0] {
        AT_SIGNATURE, AT_HDR_LEN, AT_HDR_BODY, AT_HDR_CRC,
        AT_LEN, AT_TYPE, AT_DATA, AT_CRC
    } parse_phase_e;

    typedef enum int {
        RUN_DONE, RUN_NO_IMAGE, RUN_BAD_CRC, RUN_BAD_SIG, RUN_BAD_LEN, RUN_OPEN
    } run_end_e;

    typedef struct packed {
        logic [7:0]  data;
        logic        typed;
        logic [2:0]  kind;
        logic [31:0] width;
    } hdr_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        result_t    want;
    } stim_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_payload_byte;
    logic        m_payload_valid;
    logic [2:0]  m_chunk_kind;
    logic        m_chunk_done;
    logic [2:0]  m_status;
    logic [31:0] m_image_width;
    logic [31:0] m_image_height;
    logic [7:0]  m_sample_depth;
    logic [7:0]  m_color_kind;
    logic [7:0]  m_interlace_mode;

    logic [7:0] png_magic [SIG_BYTES] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                          8'h0D, 8'h0A, 8'h1A, 8'h0A};

    hdr_row_t hdr_table [HDR_ROWS] = '{
        '{8'h89, 1'b1, KIND_OTHER,  32'h0},
        '{8'h50, 1'b1, KIND_OTHER,  32'h0},
        '{8'h4E, 1'b1, KIND_OTHER,  32'h0},
        '{8'h47, 1'b1, KIND_OTHER,  32'h0},
        '{8'h0D, 1'b1, KIND_OTHER,  32'h0},
        '{8'h0A, 1'b1, KIND_OTHER,  32'h0},
        '{8'h1A, 1'b1, KIND_OTHER,  32'h0},
        '{8'h0A, 1'b1, KIND_OTHER,  32'h0},
        '{8'h00, 1'b1, KIND_HEADER, 32'h0},
        '{8'h00, 1'b1, KIND_HEADER, 32'h0},
        '{8'h00, 1'b1, KIND_HEADER, 32'h0},
        '{8'h0D, 1'b1, KIND_HEADER, 32'h0},
        '{8'h00, 1'b1, KIND_HEADER, 32'h0},
        '{8'hFF, 1'b1, KIND_HEADER, 32'h0},
        '{8'h5A, 1'b1, KIND_HEADER, 32'h0},
        '{8'hA5, 1'b1, KIND_HEADER, 32'h0},
        '{8'hFF, 1'b1, KIND_HEADER, 32'h0000_00FF},
        '{8'hFF, 1'b1, KIND_HEADER, 32'h0000_FFFF},
        '{8'hFF, 1'b1, KIND_HEADER, 32'h00FF_FFFF},
        '{8'hFF, 1'b1, KIND_HEADER, 32'hFFFF_FFFF},
        '{8'h00, 1'b1, KIND_HEADER, 32'hFFFF_FFFF},
        '{8'h00, 1'b1, KIND_HEADER, 32'hFFFF_FFFF},
        '{8'h00, 1'b1, KIND_HEADER, 32'hFFFF_FFFF},
        '{8'h00, 1'b1, KIND_HEADER, 32'hFFFF_FFFF},
        '{8'hFF, 1'b0, KIND_HEADER, 32'h0},
        '{8'h00, 1'b0, KIND_HEADER, 32'h0},
        '{8'hFF, 1'b0, KIND_HEADER, 32'h0},
        '{8'h5A, 1'b0, KIND_HEADER, 32'h0},
        '{8'hFF, 1'b0, KIND_HEADER, 32'h0}
    };

    stim_t   stim_q [$];
    result_t pending_results [$];
    logic    cur_typed;
    result_t cur_want;
    int      send_pct = 0;
    int      stall_pct = 0;
    int      mismatch_count = 0;
    int      results_seen = 0;

    parse_phase_e ph = AT_SIGNATURE;
    logic [31:0]  cnt = '0;
    logic [31:0]  clen = '0;
    logic [31:0]  ctype_word = '0;
    logic [31:0]  crc_run = CRC_INIT;
    logic [31:0]  crc_rx = '0;
    logic         seen_idat = 1'b0;
    logic [2:0]   st = ST_BUSY;
    logic [31:0]  w_reg = '0;
    logic [31:0]  h_reg = '0;
    logic [7:0]   depth_reg = '0;
    logic [7:0]   colour_reg = '0;
    logic [7:0]   ilace_reg = '0;

    png_chunk_stream_parser u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload_byte   (m_payload_byte),
        .m_payload_valid  (m_payload_valid),
        .m_chunk_kind     (m_chunk_kind),
        .m_chunk_done     (m_chunk_done),
        .m_status         (m_status),
        .m_image_width    (m_image_width),
        .m_image_height   (m_image_height),
        .m_sample_depth   (m_sample_depth),
        .m_color_kind     (m_color_kind),
        .m_interlace_mode (m_interlace_mode)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb) r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic logic [2:0] kind_from_type(input logic [31:0] t);
        logic [2:0] k;
        case (t)
            TYPE_IDAT: k = KIND_IMAGE;
            TYPE_PLTE: k = KIND_PALETTE;
            TYPE_IEND: k = KIND_END;
            default:   k = KIND_OTHER;
        endcase
        return k;
    endfunction

    task automatic parse_byte(input logic [7:0] b, output result_t r);
        logic [2:0] kind;
        logic       pv;
        logic [7:0] pb;
        logic       done;
        kind = KIND_OTHER;
        pv = 1'b0;
        pb = 8'h00;
        done = 1'b0;
        if (st == ST_BUSY) begin
            case (ph)
                AT_SIGNATURE: begin
                    if (b != png_magic[cnt[2:0]]) begin
                        st = ST_BAD_SIG;
                    end else begin
                        cnt = cnt + 1;
                        if (cnt >= SIG_BYTES) begin
                            ph = AT_HDR_LEN;
                            cnt = '0;
                            clen = '0;
                        end
                    end
                end
                AT_HDR_LEN: begin
                    kind = KIND_HEADER;
                    clen = {clen[23:0], b};
                    cnt = cnt + 1;
                    if (cnt >= 4) begin
                        if (clen != HDR_LEN) begin
                            st = ST_BAD_HDRLEN;
                        end else begin
                            ph = AT_HDR_BODY;
                            cnt = '0;
                            crc_run = CRC_INIT;
                        end
                    end
                end
                AT_HDR_BODY: begin
                    kind = KIND_HEADER;
                    crc_run = crc_step(crc_run, b);
                    if (cnt < 4) ctype_word = {ctype_word[23:0], b};
                    else if (cnt < 8) w_reg = {w_reg[23:0], b};
                    else if (cnt < 12) h_reg = {h_reg[23:0], b};
                    else if (cnt == 12) depth_reg = b;
                    else if (cnt == 13) colour_reg = b;
                    else if (cnt == 16) ilace_reg = b;
                    cnt = cnt + 1;
                    if (cnt >= 17) begin
                        ph = AT_HDR_CRC;
                        cnt = '0;
                        crc_rx = '0;
                    end
                end
                AT_HDR_CRC: begin
                    kind = KIND_HEADER;
                    crc_rx = {crc_rx[23:0], b};
                    cnt = cnt + 1;
                    if (cnt >= 4) begin
                        done = 1'b1;
                        if (~crc_run != crc_rx) begin
                            st = ST_CRC_ERR;
                        end else begin
                            ph = AT_LEN;
                            cnt = '0;
                            clen = '0;
                        end
                    end
                end
                AT_LEN: begin
                    clen = {clen[23:0], b};
                    cnt = cnt + 1;
                    if (cnt >= 4) begin
                        ph = AT_TYPE;
                        cnt = '0;
                        crc_run = CRC_INIT;
                    end
                end
                AT_TYPE: begin
                    crc_run = crc_step(crc_run, b);
                    ctype_word = {ctype_word[23:0], b};
                    cnt = cnt + 1;
                    if (cnt >= 4) begin
                        kind = kind_from_type(ctype_word);
                        cnt = '0;
                        crc_rx = '0;
                        if (kind == KIND_END) begin
                            st = seen_idat ? ST_DONE : ST_NO_IMAGE;
                        end else begin
                            if (kind == KIND_IMAGE) seen_idat = 1'b1;
                            ph = (clen != 0) ? AT_DATA : AT_CRC;
                        end
                    end
                end
                AT_DATA: begin
                    kind = kind_from_type(ctype_word);
                    crc_run = crc_step(crc_run, b);
                    if (kind == KIND_PALETTE || kind == KIND_IMAGE) begin
                        pv = 1'b1;
                        pb = b;
                    end
                    cnt = cnt + 1;
                    if (cnt >= clen) begin
                        ph = AT_CRC;
                        cnt = '0;
                        crc_rx = '0;
                    end
                end
                default: begin
                    kind = kind_from_type(ctype_word);
                    crc_rx = {crc_rx[23:0], b};
                    cnt = cnt + 1;
                    if (cnt >= 4) begin
                        done = 1'b1;
                        if ((kind == KIND_PALETTE || kind == KIND_IMAGE) && ~crc_run != crc_rx)
                        begin
                            st = ST_CRC_ERR;
                        end else begin
                            ph = AT_LEN;
                            cnt = '0;
                            clen = '0;
                        end
                    end
                end
            endcase
        end
        r = '{payload_byte: pb, payload_valid: pv, chunk_kind: kind, chunk_done: done,
              status: st, image_width: w_reg, image_height: h_reg, sample_depth: depth_reg,
              color_kind: colour_reg, interlace_mode: ilace_reg};
    endtask

    task automatic push_byte(input logic [7:0] b);
        stim_q.push_back('{data: b, typed: 1'b0, want: '0});
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8]);
    endtask

    task automatic add_chunk(input logic [31:0] len, input logic [31:0] ctype,
                             input logic [31:0] crc_flip);
        logic [31:0] c;
        logic [7:0]  b;
        c = CRC_INIT;
        push_word(len);
        for (int i = 3; i >= 0; i--) begin
            b = ctype[8*i +: 8];
            c = crc_step(c, b);
            push_byte(b);
        end
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            c = crc_step(c, b);
            push_byte(b);
        end
        push_word(~c ^ crc_flip);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        result_t calc;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{payload_byte: m_payload_byte, payload_valid: m_payload_valid,
                        chunk_kind: m_chunk_kind, chunk_done: m_chunk_done, status: m_status,
                        image_width: m_image_width, image_height: m_image_height,
                        sample_depth: m_sample_depth, color_kind: m_color_kind,
                        interlace_mode: m_interlace_mode};
                if (pending_results.size() == 0) begin
                    report_mismatch("result transfer with nothing pending");
                end else begin
                    want = pending_results.pop_front();
                    check_field("payload_byte", 32'(got.payload_byte),
                                32'(want.payload_byte));
                    check_field("payload_valid", 32'(got.payload_valid),
                                32'(want.payload_valid));
                    check_field("chunk_kind", 32'(got.chunk_kind), 32'(want.chunk_kind));
                    check_field("chunk_done", 32'(got.chunk_done), 32'(want.chunk_done));
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("image_width", got.image_width, want.image_width);
                    check_field("image_height", got.image_height, want.image_height);
                    check_field("sample_depth", 32'(got.sample_depth),
                                32'(want.sample_depth));
                    check_field("color_kind", 32'(got.color_kind), 32'(want.color_kind));
                    check_field("interlace_mode", 32'(got.interlace_mode),
                                32'(want.interlace_mode));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                parse_byte(s_data_byte, calc);
                pending_results.push_back(cur_typed ? cur_want : calc);
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        stim_t       item;
        run_end_e    end_kind;
        logic        hdr_bad;
        logic [31:0] hcrc;
        logic [31:0] flip;
        logic [31:0] len;
        logic [31:0] ctype;
        logic [7:0]  bad;
        int          pick;
        int          pos;
        int          n;
        int          phase_now;
        int          phase_last;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = 8'h00;
        cur_typed = 1'b0;
        cur_want = '0;

        pick = $urandom_range(99);
        if (pick < 45) end_kind = RUN_DONE;
        else if (pick < 55) end_kind = RUN_NO_IMAGE;
        else if (pick < 70) end_kind = RUN_BAD_CRC;
        else if (pick < 80) end_kind = RUN_BAD_SIG;
        else if (pick < 90) end_kind = RUN_BAD_LEN;
        else end_kind = RUN_OPEN;
        hdr_bad = (end_kind == RUN_BAD_CRC) && ($urandom_range(2) == 0);
        flip = 32'h1 << $urandom_range(31);

        hcrc = CRC_INIT;
        for (int i = 0; i < HDR_ROWS; i++) begin
            if (i >= HDR_TYPE_ROW) hcrc = crc_step(hcrc, hdr_table[i].data);
            stim_q.push_back('{data: hdr_table[i].data, typed: hdr_table[i].typed,
                               want: '{payload_byte: 8'h00, payload_valid: 1'b0,
                                       chunk_kind: hdr_table[i].kind, chunk_done: 1'b0,
                                       status: ST_BUSY, image_width: hdr_table[i].width,
                                       image_height: 32'h0, sample_depth: 8'h00,
                                       color_kind: 8'h00, interlace_mode: 8'h00}});
        end
        push_word(~hcrc ^ (hdr_bad ? flip : 32'h0));

        add_chunk(32'd3, TYPE_PLTE, 32'h0);
        add_chunk(HDR_LEN, TYPE_IHDR_WORD, 32'h1);
        add_chunk(32'd0, TYPE_TEXT_WORD, 32'h0);
        if (end_kind != RUN_NO_IMAGE) begin
            add_chunk(32'd0, TYPE_IDAT, 32'h0);
            add_chunk(32'd2, TYPE_IDAT, 32'h0);
        end

        while (stim_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(96, 25) : $urandom_range(24, 1);
            if ($urandom_range(9) == 0) len = 32'h0;
            if (pick < 40) begin
                ctype = (end_kind == RUN_NO_IMAGE) ? TYPE_TEXT_WORD : TYPE_IDAT;
            end else if (pick < 55) begin
                ctype = TYPE_PLTE;
            end else if (pick < 72) begin
                ctype = $urandom;
            end else if (pick < 80) begin
                ctype = TYPE_IHDR_WORD;
            end else begin
                case ($urandom_range(2))
                    0: ctype = TYPE_IDAT;
                    1: ctype = TYPE_PLTE;
                    default: ctype = TYPE_IEND;
                endcase
                ctype = ctype ^ (32'h1 << $urandom_range(31));
            end
            if (ctype == TYPE_IDAT || ctype == TYPE_PLTE || $urandom_range(1) == 0)
                add_chunk(len, ctype, 32'h0);
            else
                add_chunk(len, ctype, 32'h1 << $urandom_range(31));
        end

        case (end_kind)
            RUN_DONE, RUN_NO_IMAGE: begin
                push_word(($urandom_range(1) == 0) ? 32'h0 : $urandom);
                push_word(TYPE_IEND);
            end
            RUN_BAD_CRC: begin
                if (!hdr_bad)
                    add_chunk($urandom_range(16, 1),
                              ($urandom_range(1) == 0) ? TYPE_IDAT : TYPE_PLTE, flip);
            end
            RUN_OPEN: begin
                push_word(32'hFFFF_FFFF - $urandom_range(255));
                push_word(TYPE_IDAT);
            end
            default: begin
            end
        endcase
        repeat (24) push_byte(8'($urandom_range(255)));

        if (end_kind == RUN_BAD_SIG || end_kind == RUN_BAD_LEN) begin
            if (end_kind == RUN_BAD_SIG) begin
                pos = $urandom_range(SIG_BYTES - 1);
                bad = png_magic[pos] ^ 8'($urandom_range(255, 1));
            end else begin
                pos = $urandom_range(HDR_TYPE_ROW - 1, SIG_BYTES);
                if (pos == HDR_TYPE_ROW - 1) bad = 8'h0D ^ 8'($urandom_range(255, 1));
                else bad = 8'($urandom_range(255, 1));
            end
            for (int i = pos; i < HDR_ROWS; i++) begin
                item = stim_q[i];
                if (i == pos) item.data = bad;
                item.typed = 1'b0;
                stim_q[i] = item;
            end
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        n = stim_q.size();
        phase_last = 0;
        for (int i = 0; i < n; i++) begin
            phase_now = (i * 4) / n;
            if (phase_now != phase_last) begin
                // hold off until the result side drains
                s_valid = 1'b0;
                while (pending_results.size() != 0) @(negedge aclk);
                phase_last = phase_now;
            end
            case (phase_now)
                0: begin
                    send_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_pct = 82;
                    stall_pct = 0;
                end
                2: begin
                    send_pct = 0;
                    stall_pct = 82;
                end
                default: begin
                    send_pct = 34;
                    stall_pct = 34;
                end
            endcase
            while (send_pct != 0 && $urandom_range(99) < send_pct) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
            item = stim_q[i];
            s_valid = 1'b1;
            s_data_byte = item.data;
            cur_typed = item.typed;
            cur_want = item.want;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
        end
        s_valid = 1'b0;

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== png_chunk_stream_parser.f =====
hw/rtl/pcsp_pkg.sv
hw/rtl/pcsp_core.sv
hw/rtl/png_chunk_stream_parser.sv
verif/tb_png_chunk_stream_parser.sv
